@@ hdl/chp_pkg.sv @@
package chp_pkg;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_ESC1 = 2'd1;
   localparam logic [1:0] MODE_ESC2 = 2'd2;
   localparam logic [1:0] MODE_MSG  = 2'd3;

   localparam logic [1:0] FMT_FULL  = 2'd0;
   localparam logic [1:0] FMT_NOSID = 2'd1;
   localparam logic [1:0] FMT_TIME  = 2'd2;
   localparam logic [1:0] FMT_NONE  = 2'd3;

   localparam logic [5:0]  ID_ESC1    = 6'd0;
   localparam logic [5:0]  ID_ESC2    = 6'd1;
   localparam logic [16:0] STREAM_OFS = 17'd64;

   typedef struct packed {
      logic [1:0]  chunk_format;
      logic [16:0] chunk_stream;
      logic [23:0] time_value;
      logic        time_present;
      logic        time_is_delta;
      logic [23:0] body_length;
      logic        length_present;
      logic [7:0]  body_type;
      logic [31:0] message_stream;
      logic        stream_present;
   } chp_result_type;

   function automatic logic [3:0] msg_len(input logic [1:0] fmt);
      logic [3:0] len;
      unique case (fmt)
         FMT_FULL:  len = 4'd11;
         FMT_NOSID: len = 4'd7;
         FMT_TIME:  len = 4'd3;
         default:   len = 4'd0;
      endcase
      return len;
   endfunction

endpackage

@@ hdl/chunk_header_parser.sv @@
// Channel | Direction | Payload
// req_    | in        | header_byte, one byte of the chunk header per beat
// rsp_    | out       | decoded header, one beat on the byte that completes a header
//
// One byte per cycle while no held result stalls the input; each byte is decoded in the cycle it is accepted.
// A result appears on rsp_ the cycle after its last header byte is accepted.
// The result register frees req_ready whenever it is empty or being taken,
// so the input stalls only while a result is held against a low rsp_ready.
// Reset is synchronous and returns the parser to the first basic-header byte.
module chunk_header_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_header_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_chunk_format,
   output logic [16:0] rsp_chunk_stream,
   output logic [23:0] rsp_time_value,
   output logic        rsp_time_present,
   output logic        rsp_time_is_delta,
   output logic [23:0] rsp_body_length,
   output logic        rsp_length_present,
   output logic [7:0]  rsp_body_type,
   output logic [31:0] rsp_message_stream,
   output logic        rsp_stream_present
);
   import chp_pkg::*;

   logic           accept;
   logic           done;
   chp_result_type result;
   logic           rsp_valid_ff, rsp_valid_in;
   chp_result_type rsp_data_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   chp_gather u_gather (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .header_byte (req_header_byte),
      .done        (done),
      .result      (result)
   );

   always_comb begin
      if (accept && done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chunk_format   = rsp_data_ff.chunk_format;
   assign rsp_chunk_stream   = rsp_data_ff.chunk_stream;
   assign rsp_time_value     = rsp_data_ff.time_value;
   assign rsp_time_present   = rsp_data_ff.time_present;
   assign rsp_time_is_delta  = rsp_data_ff.time_is_delta;
   assign rsp_body_length    = rsp_data_ff.body_length;
   assign rsp_length_present = rsp_data_ff.length_present;
   assign rsp_body_type      = rsp_data_ff.body_type;
   assign rsp_message_stream = rsp_data_ff.message_stream;
   assign rsp_stream_present = rsp_data_ff.stream_present;

endmodule

@@ hdl/chp_gather.sv @@
module chp_gather (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              header_byte,
   output logic                    done,
   output chp_pkg::chp_result_type result
);
   import chp_pkg::*;

   logic [1:0]  mode_ff,   mode_in;
   logic [3:0]  pos_ff,    pos_in;
   logic [1:0]  format_ff, format_in;
   logic [16:0] stream_ff, stream_in;
   logic [23:0] time_ff,   time_in;
   logic [23:0] length_ff, length_in;
   logic [7:0]  type_ff,   type_in;
   logic [31:0] msid_ff,   msid_in;
   logic        basic_done;
   logic [5:0]  id;

   assign id = header_byte[5:0];

   always_comb begin
      mode_in    = mode_ff;
      pos_in     = pos_ff;
      format_in  = format_ff;
      stream_in  = stream_ff;
      time_in    = time_ff;
      length_in  = length_ff;
      type_in    = type_ff;
      msid_in    = msid_ff;
      basic_done = 1'b0;
      done       = 1'b0;

      unique case (mode_ff)
         MODE_IDLE: begin
            format_in = header_byte[7:6];
            time_in   = '0;
            length_in = '0;
            type_in   = '0;
            msid_in   = '0;
            pos_in    = '0;
            if (id == ID_ESC1) begin
               mode_in = MODE_ESC1;
            end else if (id == ID_ESC2) begin
               mode_in   = MODE_ESC2;
               stream_in = '0;
            end else begin
               stream_in  = {11'd0, id};
               basic_done = 1'b1;
            end
         end
         MODE_ESC1: begin
            stream_in  = {9'd0, header_byte} + STREAM_OFS;
            basic_done = 1'b1;
         end
         MODE_ESC2: begin
            if (pos_ff == 4'd0) begin
               stream_in = {9'd0, header_byte};
               pos_in    = 4'd1;
            end else begin
               stream_in  = {1'b0, header_byte, stream_ff[7:0]} + STREAM_OFS;
               basic_done = 1'b1;
            end
         end
         default: begin
            // Timestamp and length are big-endian, the message stream id little-endian.
            unique case (pos_ff)
               4'd0, 4'd1, 4'd2: time_in   = {time_ff[15:0], header_byte};
               4'd3, 4'd4, 4'd5: time_in   = time_ff;
               default:          time_in   = time_ff;
            endcase
            unique case (pos_ff)
               4'd3, 4'd4, 4'd5: length_in = {length_ff[15:0], header_byte};
               default:          length_in = length_ff;
            endcase
            if (pos_ff == 4'd6) begin
               type_in = header_byte;
            end
            unique case (pos_ff)
               4'd7:    msid_in[7:0]   = msid_ff[7:0]   | header_byte;
               4'd8:    msid_in[15:8]  = msid_ff[15:8]  | header_byte;
               4'd9:    msid_in[23:16] = msid_ff[23:16] | header_byte;
               4'd10:   msid_in[31:24] = msid_ff[31:24] | header_byte;
               default: msid_in        = msid_ff;
            endcase
            if (({1'b0, pos_ff} + 5'd1) >= {1'b0, msg_len(format_ff)}) begin
               done    = 1'b1;
               mode_in = MODE_IDLE;
               pos_in  = '0;
            end else begin
               pos_in = pos_ff + 4'd1;
            end
         end
      endcase

      // Format three carries no message header, so it completes with the basic header.
      if (basic_done) begin
         pos_in = '0;
         if (format_in == FMT_NONE) begin
            done    = 1'b1;
            mode_in = MODE_IDLE;
         end else begin
            mode_in = MODE_MSG;
         end
      end
   end

   always_comb begin
      result.chunk_format   = format_in;
      result.chunk_stream   = stream_in;
      result.time_present   = (format_in != FMT_NONE);
      result.time_is_delta  = (format_in == FMT_NOSID) || (format_in == FMT_TIME);
      result.length_present = (format_in == FMT_FULL) || (format_in == FMT_NOSID);
      result.stream_present = (format_in == FMT_FULL);
      result.time_value     = result.time_present ? time_in : '0;
      result.body_length    = result.length_present ? length_in : '0;
      result.body_type      = result.length_present ? type_in : '0;
      result.message_stream = result.stream_present ? msid_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pos_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         pos_ff  <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         format_ff <= format_in;
         stream_ff <= stream_in;
         time_ff   <= time_in;
         length_ff <= length_in;
         type_ff   <= type_in;
         msid_ff   <= msid_in;
      end
   end

endmodule

@@ hdl/chp_checker.sv @@
module chp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_chunk_format,
   input logic [16:0] rsp_chunk_stream,
   input logic [23:0] rsp_time_value,
   input logic        rsp_time_present,
   input logic        rsp_time_is_delta,
   input logic        rsp_length_present,
   input logic [31:0] rsp_message_stream,
   input logic        rsp_stream_present
);
   import chp_pkg::*;

   // Held stream ids and timestamp must not change while the consumer stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chunk_stream)
         && $stable(rsp_message_stream) && $stable(rsp_time_value))
      else $error("result changed while stalled");

   // The input side is only held back by a result that cannot leave.
   a_req_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with a free result register");

   // Presence flags follow the header format.
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_time_present == (rsp_chunk_format != FMT_NONE))
         && (rsp_time_is_delta == (rsp_chunk_format == FMT_NOSID
            || rsp_chunk_format == FMT_TIME))
         && (rsp_length_present == (rsp_chunk_format == FMT_FULL
            || rsp_chunk_format == FMT_NOSID))
         && (rsp_stream_present == (rsp_chunk_format == FMT_FULL)))
      else $error("presence flags disagree with format");

   // Absent fields read as zero, and the escape decode never yields ids 0 or 1.
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_time_present || rsp_time_value == '0)
         && (rsp_stream_present || rsp_message_stream == '0)
         && (rsp_chunk_stream >= 17'd2))
      else $error("absent field nonzero or bad chunk stream id");

endmodule

bind chunk_header_parser chp_checker u_chp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_chunk_format   (rsp_chunk_format),
   .rsp_chunk_stream   (rsp_chunk_stream),
   .rsp_time_value     (rsp_time_value),
   .rsp_time_present   (rsp_time_present),
   .rsp_time_is_delta  (rsp_time_is_delta),
   .rsp_length_present (rsp_length_present),
   .rsp_message_stream (rsp_message_stream),
   .rsp_stream_present (rsp_stream_present)
);
